### rtl/mhid_pkg.sv
`timescale 1ns / 1ps

package mhid_pkg;

    // Heap geometry
    localparam int HEAP_DEPTH = 128;
    localparam int IDX_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
    localparam int CHILD_W    = IDX_W + 2;

    localparam int VAL_W      = 32;
    localparam int TOTAL_W    = 8;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } mhid_status_t;

    // One result as handed from the core to the output register
    typedef struct packed {
        mhid_status_t              status;
        logic [TOTAL_W-1:0]        entry_total;
        logic                      top_valid;
        logic signed [VAL_W-1:0]   top_value;
    } mhid_res_t;

endpackage

### rtl/max_heap_insert_delete_unit.sv
`timescale 1ns / 1ps

// Binary max-heap of signed 32-bit values, 128 entries.
// Input beat: tuser is the command (0 insert, 1 delete first equal entry),
// tdata the value. Output beat: tuser is the status (ok, full, not found,
// empty), tdata carries the entry count, a top-valid flag and the maximum.
// Exactly one output beat per input beat, in order.
// Full/empty rejects go straight to the done state and on to the output register.
// Insert climbs one level per parent read and compare, then places the value.
// Delete: the linear search reads one entry per cycle through the store's
// single read port, then the last entry fills the hole and is sifted down
// (read left child, read right child, compare at each level) or sifted up.
// One item is in work at a time; s_axis_tready is high while the sequencer
// is idle. The output register lets a new item start while a result waits.
// If the receiver stalls, a finished result stays in the sequencer until
// the output register frees, and no further item is taken.
// Reset empties the heap (count to zero) and clears the output valid; the
// store itself is not cleared.
module max_heap_insert_delete_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] entry_total, [8] top_valid,
                                        // [40:9] top_value, [47:41] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import mhid_pkg::*;

    logic       core_ready;
    logic       core_done;
    logic       load_out;
    mhid_res_t  core_res;
    mhid_res_t  out_reg;
    logic       out_valid_reg;

    mhid_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (s_axis_tvalid & core_ready),
        .cmd      (s_axis_tuser),
        .value    (s_axis_tdata),
        .ready    (core_ready),
        .done     (core_done),
        .done_ack (load_out),
        .res      (core_res)
    );

    assign s_axis_tready = core_ready;

    // Output register, loads when empty or being drained
    assign load_out = core_done && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = {7'd0, out_reg.top_value, out_reg.top_valid, out_reg.entry_total};

    // Checks
    a_top_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_reg.top_valid == (out_reg.entry_total != '0)))
        else $error("top_valid disagrees with entry count");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_reg.top_valid) |-> (out_reg.top_value == '0))
        else $error("top_value not zero on empty heap");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("sequencer took an item but stayed idle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_reg.status == ST_FULL))
            |-> (out_reg.entry_total == TOTAL_W'(HEAP_DEPTH)))
        else $error("full status with heap not full");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_axis_tvalid)
        else $error("finished result not presented");

endmodule

### rtl/mhid_core.sv
`timescale 1ns / 1ps

module mhid_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           cmd,
    input  logic signed [mhid_pkg::VAL_W-1:0] value,
    output logic                           ready,
    output logic                           done,
    input  logic                           done_ack,
    output mhid_pkg::mhid_res_t            res
);
    import mhid_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD_LAST,
        S_MOVE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_FIN,
        S_DONE
    } state_t;

    state_t                    state_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic signed [VAL_W-1:0]   cur_reg;
    logic signed [VAL_W-1:0]   key_reg;
    logic signed [VAL_W-1:0]   lval_reg;
    logic signed [VAL_W-1:0]   top_reg;
    logic                      first_reg;
    mhid_status_t              status_reg;
    logic [CNT_W-1:0]          scan_addr_reg;
    logic [IDX_W-1:0]          chk_idx_reg;
    logic                      chk_valid_reg;

    // Heap store, one write and one registered read per cycle
    logic signed [VAL_W-1:0]   mem [HEAP_DEPTH];
    logic signed [VAL_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VAL_W-1:0]   wr_data;

    // Index arithmetic around the current position
    logic [IDX_W-1:0]          parent_idx;
    logic [CHILD_W-1:0]        left_idx;
    logic [CHILD_W-1:0]        right_idx;
    logic [CNT_W-1:0]          last_cnt;
    logic                      left_in;
    logic                      right_in;

    // Sift-down choice of the largest of node and children
    logic signed [VAL_W-1:0]   best_val;
    logic [IDX_W-1:0]          best_idx;
    logic                      best_moves;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign left_idx   = (CHILD_W'(pos_reg) << 1) + CHILD_W'(1);
    assign right_idx  = left_idx + CHILD_W'(1);
    assign last_cnt   = count_reg - CNT_W'(1);
    assign left_in    = left_idx < CHILD_W'(count_reg);
    assign right_in   = right_idx < CHILD_W'(count_reg);

    always_comb
    begin
        best_val   = cur_reg;
        best_idx   = pos_reg;
        best_moves = 1'b0;
        if (lval_reg > best_val)
        begin
            best_val   = lval_reg;
            best_idx   = left_idx[IDX_W-1:0];
            best_moves = 1'b1;
        end
        if (right_in && (rd_data_reg > best_val))
        begin
            best_val   = rd_data_reg;
            best_idx   = right_idx[IDX_W-1:0];
            best_moves = 1'b1;
        end
    end

    // Read address by state
    always_comb
    begin
        unique case (state_reg)
            S_SCAN:    rd_addr = scan_addr_reg[IDX_W-1:0];
            S_RD_LAST: rd_addr = last_cnt[IDX_W-1:0];
            S_UP_RD:   rd_addr = parent_idx;
            S_DN_RDL:  rd_addr = left_idx[IDX_W-1:0];
            S_DN_RDR:  rd_addr = right_idx[IDX_W-1:0];
            default:   rd_addr = '0;
        endcase
    end

    // Write port: moves during sifting, final placement of the held value
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = cur_reg;
        unique case (state_reg)
            S_UP_CMP:
            begin
                wr_en   = rd_data_reg < cur_reg;
                wr_data = rd_data_reg;
            end
            S_DN_CMP:
            begin
                wr_en   = best_moves;
                wr_data = best_val;
            end
            S_FIN:
            begin
                wr_en = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            status_reg    <= ST_OK;
            first_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            pos_reg       <= '0;
            cur_reg       <= '0;
            key_reg       <= '0;
            lval_reg      <= '0;
            top_reg       <= '0;
            scan_addr_reg <= '0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            // Root copy follows every write to the top entry
            if (wr_en && (wr_addr == '0))
            begin
                top_reg <= wr_data;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        key_reg    <= value;
                        first_reg  <= 1'b0;
                        if (cmd == CMD_INSERT)
                        begin
                            if (count_reg >= CNT_W'(HEAP_DEPTH))
                            begin
                                status_reg <= ST_FULL;
                                state_reg  <= S_DONE;
                            end
                            else
                            begin
                                status_reg <= ST_OK;
                                pos_reg    <= count_reg[IDX_W-1:0];
                                cur_reg    <= value;
                                count_reg  <= count_reg + CNT_W'(1);
                                state_reg  <= (count_reg == '0) ? S_FIN : S_UP_RD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            status_reg <= ST_EMPTY;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            status_reg    <= ST_OK;
                            scan_addr_reg <= '0;
                            chk_valid_reg <= 1'b0;
                            state_reg     <= S_SCAN;
                        end
                    end
                end

                // Linear search, one read issued and one compare per cycle
                S_SCAN:
                begin
                    chk_idx_reg <= scan_addr_reg[IDX_W-1:0];
                    if (scan_addr_reg < count_reg)
                    begin
                        scan_addr_reg <= scan_addr_reg + CNT_W'(1);
                    end
                    if (chk_valid_reg && (rd_data_reg == key_reg))
                    begin
                        pos_reg       <= chk_idx_reg;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= S_RD_LAST;
                    end
                    else if (chk_valid_reg && (CNT_W'(chk_idx_reg) == last_cnt))
                    begin
                        status_reg    <= ST_NOT_FOUND;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        chk_valid_reg <= scan_addr_reg < count_reg;
                    end
                end

                S_RD_LAST:
                begin
                    state_reg <= S_MOVE;
                end

                // Last entry fills the hole; pick direction of repair
                S_MOVE:
                begin
                    cur_reg   <= rd_data_reg;
                    count_reg <= last_cnt;
                    if (CNT_W'(pos_reg) == last_cnt)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (pos_reg == '0)
                    begin
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        first_reg <= 1'b1;
                        state_reg <= S_UP_RD;
                    end
                end

                S_UP_RD:
                begin
                    state_reg <= S_UP_CMP;
                end

                S_UP_CMP:
                begin
                    first_reg <= 1'b0;
                    if (rd_data_reg < cur_reg)
                    begin
                        pos_reg   <= parent_idx;
                        state_reg <= (parent_idx == '0) ? S_FIN : S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= first_reg ? S_DN_RDL : S_FIN;
                    end
                end

                S_DN_RDL:
                begin
                    state_reg <= left_in ? S_DN_RDR : S_FIN;
                end

                S_DN_RDR:
                begin
                    lval_reg  <= rd_data_reg;
                    state_reg <= S_DN_CMP;
                end

                S_DN_CMP:
                begin
                    if (best_moves)
                    begin
                        pos_reg   <= best_idx;
                        state_reg <= S_DN_RDL;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end

                S_FIN:
                begin
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    if (done_ack)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ready = state_reg == S_IDLE;
    assign done  = state_reg == S_DONE;

    assign res.status      = status_reg;
    assign res.entry_total = TOTAL_W'(count_reg);
    assign res.top_valid   = count_reg != '0;
    assign res.top_value   = (count_reg != '0) ? top_reg : '0;

endmodule

### dv/max_heap_insert_delete_unit_tb.sv
`timescale 1ns / 1ps

import mhid_pkg::*;

// Expected-result tracker: holds its own copy of the heap, predicts one
// result per accepted command and compares it against the output beats.
class heap_scoreboard;
    logic signed [VAL_W-1:0] slots[HEAP_DEPTH];
    int unsigned             held;
    int unsigned             peak_held;
    mhid_res_t               pending[$];
    int unsigned             mismatches;
    int unsigned             inserts;
    int unsigned             deletes;
    int unsigned             status_hits[4];

    function new();
        held       = 0;
        peak_held  = 0;
        mismatches = 0;
        inserts    = 0;
        deletes    = 0;
        foreach (status_hits[i])
            status_hits[i] = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
        logic signed [VAL_W-1:0] t;
        t        = slots[a];
        slots[a] = slots[b];
        slots[b] = t;
    endfunction

    // Climb toward the root while the parent is smaller
    function void sift_up(int unsigned p);
        int unsigned up;
        while (p != 0)
        begin
            up = (p - 1) / 2;
            if (!(slots[up] < slots[p]))
                break;
            swap_slots(p, up);
            p = up;
        end
    endfunction

    // Random value currently held, for well-formed deletes
    function logic signed [VAL_W-1:0] pick_held();
        return slots[$urandom_range(0, held - 1)];
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] MISMATCH %s", $time, what);
    endfunction

    // Accepted command: update the heap copy and queue the expected result
    function void note_command(logic cmd, logic signed [VAL_W-1:0] v);
        mhid_res_t   r;
        int unsigned p;
        int unsigned c;
        int unsigned big;
        r.status = ST_OK;
        if (cmd == CMD_INSERT)
        begin
            inserts++;
            if (held >= HEAP_DEPTH)
                r.status = ST_FULL;
            else
            begin
                slots[held] = v;
                held++;
                sift_up(held - 1);
            end
        end
        else
        begin
            deletes++;
            if (held == 0)
                r.status = ST_EMPTY;
            else
            begin
                p = 0;
                while (p < held && slots[p] != v)
                    p++;
                if (p == held)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // last entry fills the hole, then order is restored
                    held--;
                    slots[p] = slots[held];
                    if (p < held)
                    begin
                        if (p != 0 && slots[(p - 1) / 2] < slots[p])
                            sift_up(p);
                        else
                        begin
                            forever
                            begin
                                big = p;
                                c   = 2 * p + 1;
                                if (c < held && slots[c] > slots[big])
                                    big = c;
                                if (c + 1 < held && slots[c + 1] > slots[big])
                                    big = c + 1;
                                if (big == p)
                                    break;
                                swap_slots(p, big);
                                p = big;
                            end
                        end
                    end
                end
            end
        end
        if (held > peak_held)
            peak_held = held;
        status_hits[r.status]++;
        r.entry_total = TOTAL_W'(held);
        r.top_valid   = (held != 0);
        r.top_value   = (held != 0) ? slots[0] : '0;
        pending.push_back(r);
    endfunction

    // Output beat: compare against the oldest expectation
    function void check_result(logic [1:0] st, logic [47:0] d);
        mhid_res_t e;
        if (pending.size() == 0)
        begin
            flag($sformatf("unexpected beat: status %0d data %h", st, d));
            return;
        end
        e = pending.pop_front();
        if (st !== e.status || d[7:0] !== e.entry_total || d[8] !== e.top_valid
            || d[40:9] !== e.top_value || d[47:41] !== 7'd0)
            flag($sformatf({"exp status %0d total %0d top_valid %0d top %0d | ",
                            "got status %0d total %0d top_valid %0d top %0d pad %h"},
                           e.status, e.entry_total, e.top_valid, e.top_value,
                           st, d[7:0], d[8], $signed(d[40:9]), d[47:41]));
    endfunction
endclass

module max_heap_insert_delete_unit_tb;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned RANDOM_ITEMS = 1930;
    localparam int unsigned HOLD_AT      = 700;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] value
    logic        s_axis_tuser = 1'b0;   // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // [7:0] entry_total, [8] top_valid,
                                        // [40:9] top_value, [47:41] zero
    logic [1:0]  m_axis_tuser;          // [1:0] status

    heap_scoreboard sb = new();

    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned rx_gap = 0;
    bit          rx_quiet = 1'b0;
    bit          rx_hold = 1'b0;
    bit          tx_quiet = 1'b0;
    int unsigned errors;

    max_heap_insert_delete_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int unsigned draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 15);
    endfunction

    // Mix of extremes, a narrow band for duplicates, and full-range values
    function automatic logic signed [31:0] draw_value();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else if (pick <= 3)
            return $signed($urandom_range(0, 40)) - 32'sd20;
        else
            return $signed($urandom());
    endfunction

    // Receiver: random stall per beat, quiet stretches, plus the long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tuser, m_axis_tdata);
                beats_seen++;
                if (beats_seen % 50 == 0)
                    rx_quiet = ($urandom_range(0, 2) == 0);
                rx_gap = draw_gap(rx_quiet);
            end
            else if (rx_gap > 0)
                rx_gap--;
            m_axis_tready <= (rx_gap == 0) && !rx_hold;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (items_sent >= HOLD_AT);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Send one command beat; returns at the edge where it was accepted
    task automatic send_cmd(input logic cmd, input logic signed [31:0] v);
        int unsigned gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(cmd, v);
        items_sent++;
        if (items_sent % 50 == 0)
            tx_quiet = ($urandom_range(0, 2) == 0);
    endtask

    // Phases alternate fill-heavy, drain-heavy and balanced traffic
    task automatic run_random(input int unsigned count);
        int unsigned      left_in_phase;
        int unsigned      insert_pct;
        int unsigned      phase_no;
        logic             cmd;
        logic signed [31:0] v;
        left_in_phase = 0;
        insert_pct    = 85;
        phase_no      = 0;
        for (int unsigned n = 0; n < count; n++)
        begin
            if (left_in_phase == 0)
            begin
                case (phase_no % 3)
                    0:       insert_pct = 85;
                    1:       insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                left_in_phase = $urandom_range(150, 300);
                phase_no++;
            end
            left_in_phase--;
            if ($urandom_range(0, 99) < insert_pct)
            begin
                cmd = CMD_INSERT;
                v   = draw_value();
            end
            else
            begin
                cmd = CMD_DELETE;
                if (sb.held != 0 && $urandom_range(0, 9) < 8)
                    v = sb.pick_held();
                else
                    v = draw_value();
            end
            send_cmd(cmd, v);
        end
    endtask

    // Main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty delete, extremes, duplicates, miss, root/leaf/middle deletes
        send_cmd(CMD_DELETE, 32'sd5);
        send_cmd(CMD_INSERT, 32'sd0);
        send_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        send_cmd(CMD_INSERT, 32'sh8000_0000);
        send_cmd(CMD_INSERT, -32'sd1);
        send_cmd(CMD_INSERT, 32'sd1);
        send_cmd(CMD_INSERT, 32'sh7FFF_FFFF);
        send_cmd(CMD_DELETE, 32'sd12345);
        send_cmd(CMD_DELETE, 32'sh7FFF_FFFF);
        send_cmd(CMD_DELETE, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 32'sd100);
        send_cmd(CMD_INSERT, 32'sd50);
        send_cmd(CMD_INSERT, 32'sd75);
        send_cmd(CMD_INSERT, 32'sd200);
        send_cmd(CMD_DELETE, 32'sd0);
        send_cmd(CMD_DELETE, 32'sh7FFF_FFFF);
        send_cmd(CMD_DELETE, -32'sd1);
        send_cmd(CMD_DELETE, 32'sd1);
        send_cmd(CMD_DELETE, 32'sd100);
        send_cmd(CMD_DELETE, 32'sd50);
        send_cmd(CMD_DELETE, 32'sd75);
        send_cmd(CMD_DELETE, 32'sd200);
        send_cmd(CMD_DELETE, 32'sd200);

        run_random(RANDOM_ITEMS);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray beats
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        errors = sb.mismatches + sb.pending.size();
        $display("Covered %0d commands (%0d insert, %0d delete), peak fill %0d of %0d",
                 items_sent, sb.inserts, sb.deletes, sb.peak_held, HEAP_DEPTH);
        $display("Status mix: ok %0d, full %0d, not found %0d, empty %0d; %0d mismatches",
                 sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_EMPTY], errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
